FILE: rtl/ieem_pkg.sv
// Shared types and codes for the I2C target EEPROM emulation core.
// No dependencies; imported by the core and by the address reducer.
package ieem_pkg;

    // Bus event codes carried on the input tuser
    typedef enum logic [1:0] {
        FN_WRITE = 2'd0,
        FN_READ  = 2'd1,
        FN_STOP  = 2'd2
    } t_func;

    // Address / data phase of the emulated EEPROM
    typedef enum logic [1:0] {
        PH_ADDR_HI = 2'd0,
        PH_ADDR_LO = 2'd1,
        PH_DATA    = 2'd2
    } t_phase;

    // Control sequencer
    typedef enum logic [1:0] {
        ST_CLEAR  = 2'd0,
        ST_IDLE   = 2'd1,
        ST_READ   = 2'd2,
        ST_REDUCE = 2'd3
    } t_state;

    localparam int ADDR_BITS = 16;

    // Request to / response from the address reducer
    typedef struct packed {
        logic                 start;
        logic [ADDR_BITS-1:0] value;
    } t_red_req;

    typedef struct packed {
        logic                 done;
        logic [ADDR_BITS-1:0] rem;
    } t_red_rsp;

endpackage

FILE: rtl/i2c_target_eeprom_emulation_core.sv
// I2C target EEPROM emulation core (24C style, two-byte word address).
// Depends on ieem_pkg, ieem_mem (byte store) and ieem_mod (address reducer).
//
// Usage:
//   Slave stream: one transaction per bus event. tuser carries the event
//   kind (write byte, read byte, stop), tdata the byte written by the
//   controller. Master stream: one transaction per read event, tdata is
//   the stored byte at the pointer before it advances.
//   After a stop the first two written bytes load the word pointer (high
//   byte first, reduced modulo MEM_DEPTH); later written bytes are stored.
// Timing:
//   Data write, stop and unused codes complete in the idle state. A read
//   goes through a synchronous memory read, then the output register,
//   where it may wait for m_axis_tready. An address byte passes the two
//   reducer stages (quotient, remainder), then the pointer load.
// Reset:
//   A clearing pass writes zero to every entry with s_axis_tready low.
//   Pointer and phase reset to zero / high address byte.
// Stall:
//   The output register holds a finished result while m_axis_tready is low;
//   other events are still accepted, a further read waits in its read state.
module i2c_target_eeprom_emulation_core #(
    parameter int MEM_DEPTH = 1024
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] write_data
    input  logic [1:0] s_axis_tuser,   // [1:0] func
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata    // [7:0] read_data
);
    import ieem_pkg::*;

    localparam int            AW   = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam logic [AW-1:0] LAST = AW'(MEM_DEPTH - 1);

    t_state        r_state,    n_state;
    t_phase        r_phase,    n_phase;
    logic [AW-1:0] r_ptr,      n_ptr;
    logic [7:0]    r_addr_hi,  n_addr_hi;
    logic [AW-1:0] r_clr_addr, n_clr_addr;
    logic          r_out_vld,  n_out_vld;
    logic [7:0]    r_out_data, n_out_data;

    logic          w_accept;
    logic [AW-1:0] w_ptr_inc;
    logic          w_we, w_re;
    logic [AW-1:0] w_waddr;
    logic [7:0]    w_wdata;
    logic [7:0]    w_rdata;
    t_red_req      w_red_req;
    t_red_rsp      w_red_rsp;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    // pointer always stays below MEM_DEPTH, so wrap is a single compare
    assign w_ptr_inc     = (r_ptr == LAST) ? '0 : r_ptr + 1'b1;

    ieem_mem #(
        .MEM_DEPTH (MEM_DEPTH),
        .AW        (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (r_ptr),
        .o_rdata (w_rdata)
    );

    ieem_mod #(
        .MEM_DEPTH (MEM_DEPTH)
    ) u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_red_req),
        .o_rsp   (w_red_rsp)
    );

    always_comb begin
        n_state    = r_state;
        n_phase    = r_phase;
        n_ptr      = r_ptr;
        n_addr_hi  = r_addr_hi;
        n_clr_addr = r_clr_addr;
        n_out_vld  = r_out_vld && !m_axis_tready;
        n_out_data = r_out_data;
        w_we       = 1'b0;
        w_waddr    = r_ptr;
        w_wdata    = s_axis_tdata;
        w_re       = 1'b0;
        w_red_req  = '{start: 1'b0, value: '0};

        unique case (r_state)
            ST_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_clr_addr;
                w_wdata = '0;
                if (r_clr_addr == LAST) begin
                    n_state = ST_IDLE;
                end else begin
                    n_clr_addr = r_clr_addr + 1'b1;
                end
            end
            ST_IDLE: begin
                if (w_accept) begin
                    case (t_func'(s_axis_tuser))
                        FN_WRITE: begin
                            unique case (r_phase)
                                PH_ADDR_HI: begin
                                    n_addr_hi = s_axis_tdata;
                                    n_phase   = PH_ADDR_LO;
                                    w_red_req = '{start: 1'b1,
                                                  value: {s_axis_tdata, 8'h00}};
                                    n_state   = ST_REDUCE;
                                end
                                PH_ADDR_LO: begin
                                    n_phase   = PH_DATA;
                                    w_red_req = '{start: 1'b1,
                                                  value: {r_addr_hi, s_axis_tdata}};
                                    n_state   = ST_REDUCE;
                                end
                                PH_DATA: begin
                                    w_we  = 1'b1;
                                    n_ptr = w_ptr_inc;
                                end
                                default: begin
                                end
                            endcase
                        end
                        FN_READ: begin
                            // memory samples r_ptr at this edge
                            w_re    = 1'b1;
                            n_ptr   = w_ptr_inc;
                            n_state = ST_READ;
                        end
                        FN_STOP: begin
                            n_phase = PH_ADDR_HI;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_READ: begin
                // hold here until the output register is free
                if (!r_out_vld || m_axis_tready) begin
                    n_out_vld  = 1'b1;
                    n_out_data = w_rdata;
                    n_state    = ST_IDLE;
                end
            end
            ST_REDUCE: begin
                if (w_red_rsp.done) begin
                    n_ptr   = AW'(w_red_rsp.rem);
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_phase    <= PH_ADDR_HI;
            r_ptr      <= '0;
            r_addr_hi  <= '0;
            r_clr_addr <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_phase    <= n_phase;
            r_ptr      <= n_ptr;
            r_addr_hi  <= n_addr_hi;
            r_clr_addr <= n_clr_addr;
            r_out_vld  <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;

    // pointer never leaves the memory range
    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ptr <= LAST)
        else $error("pointer beyond memory depth");

    // an accepted read always moves to the read state
    a_read_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && s_axis_tuser == FN_READ) |=> (r_state == ST_READ))
        else $error("read event not followed by read state");

    // reducer finishes only while the sequencer waits for it
    a_red_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_red_rsp.done |-> (r_state == ST_REDUCE))
        else $error("reducer done outside reduce state");
endmodule

FILE: rtl/ieem_mem.sv
// Byte store of the emulated EEPROM: one write port, one read port,
// registered read data. Depends on nothing.
module ieem_mem #(
    parameter int MEM_DEPTH = 1024,
    parameter int AW        = 10
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);
    logic [7:0] r_mem [MEM_DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

FILE: rtl/ieem_mod.sv
// Reduction of a 16-bit word address modulo MEM_DEPTH by reciprocal
// multiplication, two pipelined stages. Depends on ieem_pkg.
module ieem_mod #(
    parameter int MEM_DEPTH = 1024
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ieem_pkg::t_red_req i_req,
    output ieem_pkg::t_red_rsp o_rsp
);
    import ieem_pkg::*;

    // q = (v * RECIP) >> QSHIFT is the exact quotient for every 16-bit v
    localparam int            LOG_D   = $clog2(MEM_DEPTH);
    localparam int            QSHIFT  = ADDR_BITS + LOG_D;
    localparam int            MW      = ADDR_BITS + 1;
    localparam int            PW      = ADDR_BITS + MW;
    localparam logic [63:0]   RECIP_W = ((64'd1 << QSHIFT) / 64'(MEM_DEPTH)) + 64'd1;
    localparam logic [PW-1:0] RECIP   = PW'(RECIP_W);
    localparam logic [PW-1:0] DIVSR   = PW'(MEM_DEPTH);

    logic [PW-1:0]        w_prod_q;
    logic [PW-1:0]        w_prod_qd;
    logic [ADDR_BITS-1:0] w_quot;
    logic [ADDR_BITS-1:0] w_rem;
    logic                 r_s1_vld;
    logic                 r_done;
    logic [ADDR_BITS-1:0] r_val;
    logic [ADDR_BITS-1:0] r_quot;
    logic [ADDR_BITS-1:0] r_rem;

    // stage 1: quotient
    assign w_prod_q = PW'(i_req.value) * RECIP;
    assign w_quot   = ADDR_BITS'(w_prod_q >> QSHIFT);

    // stage 2: remainder = value - quotient * MEM_DEPTH
    assign w_prod_qd = PW'(r_quot) * DIVSR;
    assign w_rem     = ADDR_BITS'(PW'(r_val) - w_prod_qd);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_s1_vld <= i_req.start;
            r_done   <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_val  <= i_req.value;
            r_quot <= w_quot;
        end
        if (r_s1_vld) begin
            r_rem <= w_rem;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.rem  = r_rem;
endmodule
